@@ sv/isws_pkg.sv @@
// Shared types and constants for the indexed stack with search.
package isws_pkg;

    localparam int OP_W     = 3;
    localparam int POS_W    = 8;
    localparam int VAL_W    = 32;
    localparam int FOUND_W  = 9;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;

    // Reported by find when no entry holds the key.
    localparam logic [FOUND_W-1:0] NOT_FOUND = {FOUND_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_SET   = 3'd2,
        OP_GET   = 3'd3,
        OP_FIND  = 3'd4,
        OP_CLEAR = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_DECODE = 3'd1,
        S_RDWAIT = 3'd2,
        S_FILL   = 3'd3,
        S_FIND   = 3'd4,
        S_DONE   = 3'd5
    } t_state;

endpackage

@@ sv/isws_if.sv @@
// Request and response channel interfaces for the indexed stack with search.
interface isws_req_if;
    logic                              valid;
    logic                              ready;
    logic [isws_pkg::OP_W-1:0]         operation;
    logic [isws_pkg::POS_W-1:0]        position;
    logic signed [isws_pkg::VAL_W-1:0] value;

    modport source (output valid, operation, position, value, input ready);
    modport sink   (input valid, operation, position, value, output ready);
endinterface

interface isws_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [isws_pkg::VAL_W-1:0]   read_value;
    logic signed [isws_pkg::FOUND_W-1:0] found_position;
    logic [isws_pkg::COUNT_W-1:0]        count;
    logic [isws_pkg::STATUS_W-1:0]       status;

    modport source (output valid, read_value, found_position, count, status, input ready);
    modport sink   (input valid, read_value, found_position, count, status, output ready);
endinterface

@@ sv/isws_ram.sv @@
// Entry storage: one write port, one read port with registered read data.
module isws_ram #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]      i_wr_addr,
    input  logic [DATA_WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0]      i_rd_addr,
    output logic [DATA_WIDTH-1:0]         o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/indexed_stack_with_search.sv @@
// Top level of the indexed stack with search.
//
// A bounded stack of DEPTH signed words, DATA_WIDTH bits each, held in a
// single-port-write, single-port-read RAM, with an occupancy count. Each
// request carries an operation: push, pop, set, get, find or clear, and
// yields exactly one response with the read value, the found position,
// the count after the operation and a status (ok, full, empty, index out
// of range). One request is worked on at a time; a small sequencer drives
// the RAM port and a single compare/increment unit. From accepting a
// request it steps through decode, then done, then back to idle: pop
// and get take a RAM read wait between decode and done unless they
// report empty or out of range; set beyond the count first fills from
// the count up to the position, one zero-fill write per cycle, ending
// with the value; find examines entries up to the first match, or the
// whole count when absent, one compare per cycle fed by a pipelined RAM
// read. The RAM read port is what bounds find and the write port what
// bounds gap filling. A finished response waits in an output register,
// so the next request is accepted while the previous response is still
// unclaimed; a request only stalls at its end if that register is still
// full. Entries need no clearing after reset: only entries below the
// count are ever read.
module indexed_stack_with_search #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    isws_req_if.sink    i_req,
    isws_rsp_if.source  o_rsp
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > isws_pkg::COUNT_W) ? CW : isws_pkg::COUNT_W;

    // Control state
    isws_pkg::t_state  r_state, n_state;
    logic [CW-1:0]     r_occ, n_occ;
    logic              r_out_valid, n_out_valid;

    // Request and working payload
    isws_pkg::t_op                   r_op, n_op;
    logic [isws_pkg::POS_W-1:0]      r_pos, n_pos;
    logic [DATA_WIDTH-1:0]           r_key, n_key;
    logic [AW-1:0]                   r_idx, n_idx;
    logic [isws_pkg::VAL_W-1:0]      r_res_read, n_res_read;
    logic [isws_pkg::FOUND_W-1:0]    r_res_found, n_res_found;
    isws_pkg::t_status               r_res_status, n_res_status;

    // Response register
    logic [isws_pkg::VAL_W-1:0]      r_out_read, n_out_read;
    logic [isws_pkg::FOUND_W-1:0]    r_out_found, n_out_found;
    logic [isws_pkg::COUNT_W-1:0]    r_out_count, n_out_count;
    isws_pkg::t_status               r_out_status, n_out_status;

    // RAM port
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    // Width conversions between the 32-bit fields and stored words
    logic signed [63:0]    key_wide;
    logic signed [63:0]    rd_wide;

    // Common-width views for the compares
    logic [CMPW-1:0] pos_x;
    logic [CMPW-1:0] occ_x;
    logic [CMPW-1:0] idx_x;
    logic [CMPW-1:0] depth_x;

    assign key_wide = 64'(i_req.value);
    assign rd_wide  = 64'($signed(rd_data));
    assign pos_x    = CMPW'(r_pos);
    assign occ_x    = CMPW'(r_occ);
    assign idx_x    = CMPW'(r_idx);
    assign depth_x  = CMPW'(DEPTH);

    isws_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign i_req.ready          = (r_state == isws_pkg::S_IDLE);
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.read_value     = r_out_read;
    assign o_rsp.found_position = r_out_found;
    assign o_rsp.count          = r_out_count;
    assign o_rsp.status         = r_out_status;

    // Sequencer: next state, RAM control and working registers
    always_comb begin
        n_state      = r_state;
        n_occ        = r_occ;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_op         = r_op;
        n_pos        = r_pos;
        n_key        = r_key;
        n_idx        = r_idx;
        n_res_read   = r_res_read;
        n_res_found  = r_res_found;
        n_res_status = r_res_status;
        n_out_read   = r_out_read;
        n_out_found  = r_out_found;
        n_out_count  = r_out_count;
        n_out_status = r_out_status;
        wr_en        = 1'b0;
        wr_addr      = r_idx;
        wr_data      = r_key;
        rd_addr      = r_idx;

        case (r_state)
            isws_pkg::S_IDLE: begin
                // Latch the request and clear the result fields
                if (i_req.valid) begin
                    n_op         = isws_pkg::t_op'(i_req.operation);
                    n_pos        = i_req.position;
                    n_key        = key_wide[DATA_WIDTH-1:0];
                    n_res_read   = '0;
                    n_res_found  = '0;
                    n_res_status = isws_pkg::ST_OK;
                    n_state      = isws_pkg::S_DECODE;
                end
            end

            isws_pkg::S_DECODE: begin
                n_state = isws_pkg::S_DONE;
                case (r_op)
                    isws_pkg::OP_PUSH: begin
                        if (occ_x == depth_x) begin
                            n_res_status = isws_pkg::ST_FULL;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = r_occ[AW-1:0];
                            n_occ   = r_occ + 1'b1;
                        end
                    end
                    isws_pkg::OP_POP: begin
                        if (r_occ == '0) begin
                            n_res_status = isws_pkg::ST_EMPTY;
                        end else begin
                            n_occ   = r_occ - 1'b1;
                            rd_addr = n_occ[AW-1:0];
                            n_state = isws_pkg::S_RDWAIT;
                        end
                    end
                    isws_pkg::OP_SET: begin
                        if (pos_x >= depth_x) begin
                            n_res_status = isws_pkg::ST_RANGE;
                        end else if (pos_x < occ_x) begin
                            wr_en   = 1'b1;
                            wr_addr = pos_x[AW-1:0];
                        end else begin
                            // Zero-fill from the count up to the position
                            n_idx   = r_occ[AW-1:0];
                            n_state = isws_pkg::S_FILL;
                        end
                    end
                    isws_pkg::OP_GET: begin
                        if (pos_x >= occ_x) begin
                            n_res_status = isws_pkg::ST_RANGE;
                        end else begin
                            rd_addr = pos_x[AW-1:0];
                            n_state = isws_pkg::S_RDWAIT;
                        end
                    end
                    isws_pkg::OP_FIND: begin
                        n_res_found = isws_pkg::NOT_FOUND;
                        if (r_occ != '0) begin
                            rd_addr = '0;
                            n_idx   = '0;
                            n_state = isws_pkg::S_FIND;
                        end
                    end
                    isws_pkg::OP_CLEAR: begin
                        n_occ = '0;
                    end
                    default: begin
                    end
                endcase
            end

            isws_pkg::S_RDWAIT: begin
                n_res_read = rd_wide[isws_pkg::VAL_W-1:0];
                n_state    = isws_pkg::S_DONE;
            end

            isws_pkg::S_FILL: begin
                wr_en   = 1'b1;
                wr_addr = r_idx;
                if (idx_x == pos_x) begin
                    wr_data = r_key;
                    n_occ   = CW'(pos_x + 1'b1);
                    n_state = isws_pkg::S_DONE;
                end else begin
                    wr_data = '0;
                    n_idx   = r_idx + 1'b1;
                end
            end

            isws_pkg::S_FIND: begin
                // Compare the word of r_idx while reading the next one
                rd_addr = r_idx + 1'b1;
                if (rd_data == r_key) begin
                    n_res_found = isws_pkg::FOUND_W'(r_idx);
                    n_state     = isws_pkg::S_DONE;
                end else if ((idx_x + 1'b1) == occ_x) begin
                    n_state = isws_pkg::S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            isws_pkg::S_DONE: begin
                // Hold until the response register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_read   = r_res_read;
                    n_out_found  = r_res_found;
                    n_out_count  = isws_pkg::COUNT_W'(r_occ);
                    n_out_status = r_res_status;
                    n_state      = isws_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = isws_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= isws_pkg::S_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_pos        <= n_pos;
        r_key        <= n_key;
        r_idx        <= n_idx;
        r_res_read   <= n_res_read;
        r_res_found  <= n_res_found;
        r_res_status <= n_res_status;
        r_out_read   <= n_out_read;
        r_out_found  <= n_out_found;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
    end

`ifndef SYNTHESIS
    // The count never passes the capacity
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occ_x <= depth_x)
        else $error("occupancy above capacity");

    // An accepted request is decoded in the next cycle
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == isws_pkg::S_DECODE))
        else $error("accepted request not decoded");

    // A full status is only reported with the store at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == isws_pkg::ST_FULL)
            |-> (r_out_count == isws_pkg::COUNT_W'(DEPTH)))
        else $error("full status with spare room");

    // An empty status is only reported with nothing stored
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == isws_pkg::ST_EMPTY) |-> (r_out_count == '0))
        else $error("empty status with entries stored");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the indexed stack with search.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH    = 256;
    localparam int SHADOW_AW      = $clog2(STACK_DEPTH);
    localparam int DATA_BITS      = 32;
    localparam int RANDOM_ITEMS   = 625;
    // Longest request is a find over a full store.
    localparam int SETTLE_CYCLES  = STACK_DEPTH + 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int IDLE_PCT       = 29;

    // Operation codes the block decodes as no-ops.
    localparam logic [isws_pkg::OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [isws_pkg::OP_W-1:0] OP_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [isws_pkg::VAL_W-1:0]   read_value;
        logic [isws_pkg::FOUND_W-1:0] found_position;
        logic [isws_pkg::COUNT_W-1:0] count;
        isws_pkg::t_status            status;
    } t_stack_rsp;

    typedef struct packed {
        logic [isws_pkg::OP_W-1:0]  op;
        logic [isws_pkg::POS_W-1:0] pos;
        logic [isws_pkg::VAL_W-1:0] val;
        logic                       typed;    // rsp holds a hand-written expectation
        t_stack_rsp                 rsp;
    } t_stim_row;

    localparam t_stack_rsp NO_RSP = '0;
    localparam int N_DIRECTED = 25;

    // Directed requests. Rows marked typed carry their expected response;
    // the rest take theirs from the shadow stack below.
    localparam t_stim_row DIRECTED_ROWS [N_DIRECTED] = '{
        // empty store: underflow, get out of range, find misses
        '{isws_pkg::OP_POP,   8'd0,   32'h0000_0000, 1'b1,
          '{32'h0, 9'd0, 9'd0, isws_pkg::ST_EMPTY}},
        '{isws_pkg::OP_GET,   8'd0,   32'h0000_0000, 1'b1,
          '{32'h0, 9'd0, 9'd0, isws_pkg::ST_RANGE}},
        '{isws_pkg::OP_FIND,  8'd0,   32'h0000_0000, 1'b1,
          '{32'h0, isws_pkg::NOT_FOUND, 9'd0, isws_pkg::ST_OK}},
        // value extremes
        '{isws_pkg::OP_PUSH,  8'd0,   32'h7FFF_FFFF, 1'b1,
          '{32'h0, 9'd0, 9'd1, isws_pkg::ST_OK}},
        '{isws_pkg::OP_PUSH,  8'd0,   32'h8000_0000, 1'b1,
          '{32'h0, 9'd0, 9'd2, isws_pkg::ST_OK}},
        '{isws_pkg::OP_PUSH,  8'd0,   32'hFFFF_FFFF, 1'b1,
          '{32'h0, 9'd0, 9'd3, isws_pkg::ST_OK}},
        '{isws_pkg::OP_GET,   8'd1,   32'h0000_0000, 1'b1,
          '{32'h8000_0000, 9'd0, 9'd3, isws_pkg::ST_OK}},
        '{isws_pkg::OP_FIND,  8'd0,   32'hFFFF_FFFF, 1'b1,
          '{32'h0, 9'd2, 9'd3, isws_pkg::ST_OK}},
        '{isws_pkg::OP_FIND,  8'd0,   32'h1234_5678, 1'b1,
          '{32'h0, isws_pkg::NOT_FOUND, 9'd3, isws_pkg::ST_OK}},
        // set inside the range, then beyond it with a zero fill
        '{isws_pkg::OP_SET,   8'd1,   32'h55AA_55AA, 1'b0, NO_RSP},
        '{isws_pkg::OP_SET,   8'd9,   32'h0000_0001, 1'b0, NO_RSP},
        '{isws_pkg::OP_GET,   8'd5,   32'h0000_0000, 1'b0, NO_RSP},
        '{isws_pkg::OP_FIND,  8'd0,   32'h0000_0000, 1'b0, NO_RSP},
        '{isws_pkg::OP_GET,   8'd10,  32'h0000_0000, 1'b1,
          '{32'h0, 9'd0, 9'd10, isws_pkg::ST_RANGE}},
        '{isws_pkg::OP_POP,   8'd0,   32'h0000_0000, 1'b0, NO_RSP},
        // unused codes change nothing
        '{OP_UNUSED_6, 8'hFF, 32'hFFFF_FFFF, 1'b0, NO_RSP},
        '{OP_UNUSED_7, 8'h00, 32'h0000_0000, 1'b0, NO_RSP},
        '{isws_pkg::OP_PUSH,  8'd0,   32'h8000_0000, 1'b0, NO_RSP},
        // fill to the top, then overflow
        '{isws_pkg::OP_SET,   8'd255, 32'hDEAD_BEEF, 1'b0, NO_RSP},
        '{isws_pkg::OP_PUSH,  8'd0,   32'h0000_0001, 1'b1,
          '{32'h0, 9'd0, 9'd256, isws_pkg::ST_FULL}},
        '{isws_pkg::OP_GET,   8'd255, 32'h0000_0000, 1'b0, NO_RSP},
        '{isws_pkg::OP_FIND,  8'd0,   32'hA5A5_A5A5, 1'b0, NO_RSP},
        '{isws_pkg::OP_SET,   8'd0,   32'hFFFF_FFFF, 1'b0, NO_RSP},
        '{isws_pkg::OP_CLEAR, 8'd0,   32'h0000_0000, 1'b1,
          '{32'h0, 9'd0, 9'd0, isws_pkg::ST_OK}},
        '{isws_pkg::OP_POP,   8'd0,   32'h0000_0000, 1'b1,
          '{32'h0, 9'd0, 9'd0, isws_pkg::ST_EMPTY}}
    };

    logic i_clk;
    logic i_rst_n;

    isws_req_if req_bus ();
    isws_rsp_if rsp_bus ();

    indexed_stack_with_search #(
        .DEPTH      (STACK_DEPTH),
        .DATA_WIDTH (DATA_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // Shadow copy of the stack, advanced once per accepted request.
    logic [isws_pkg::VAL_W-1:0] shadow_mem [STACK_DEPTH];
    int unsigned                shadow_count;

    // Responses still owed by the block, oldest first.
    t_stack_rsp pending_rsp_q [$];

    int  err_count;
    int  rsp_seen;
    int  quiet_cycles;
    // While set, neither side inserts bubbles.
    bit  calm;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Print one line per failure and count it.
    task automatic flag_error(input string what);
        err_count++;
        $display("[%0t] MISMATCH %s", $realtime, what);
    endtask

    // Apply one request to the shadow stack and return the response it owes.
    function automatic t_stack_rsp apply_stack_op(input logic [isws_pkg::OP_W-1:0] op,
                                                  input logic [isws_pkg::POS_W-1:0] pos,
                                                  input logic [isws_pkg::VAL_W-1:0] val);
        t_stack_rsp r;
        int unsigned idx;
        r        = '0;
        r.status = isws_pkg::ST_OK;
        case (op)
            isws_pkg::OP_PUSH: begin
                if (shadow_count >= STACK_DEPTH) begin
                    r.status = isws_pkg::ST_FULL;
                end else begin
                    shadow_mem[SHADOW_AW'(shadow_count)] = val;
                    shadow_count++;
                end
            end
            isws_pkg::OP_POP: begin
                if (shadow_count == 0) begin
                    r.status = isws_pkg::ST_EMPTY;
                end else begin
                    shadow_count--;
                    r.read_value = shadow_mem[SHADOW_AW'(shadow_count)];
                end
            end
            isws_pkg::OP_SET: begin
                if (int'(pos) >= STACK_DEPTH) begin
                    r.status = isws_pkg::ST_RANGE;
                end else begin
                    // zero the gap between the old top and the target
                    for (idx = shadow_count; idx < pos; idx++) begin
                        shadow_mem[SHADOW_AW'(idx)] = '0;
                    end
                    shadow_mem[pos] = val;
                    if (pos >= shadow_count) begin
                        shadow_count = 32'(pos) + 32'd1;
                    end
                end
            end
            isws_pkg::OP_GET: begin
                if (pos >= shadow_count) begin
                    r.status = isws_pkg::ST_RANGE;
                end else begin
                    r.read_value = shadow_mem[pos];
                end
            end
            isws_pkg::OP_FIND: begin
                r.found_position = isws_pkg::NOT_FOUND;
                for (idx = 0; idx < shadow_count; idx++) begin
                    if (shadow_mem[SHADOW_AW'(idx)] == val) begin
                        r.found_position = idx[isws_pkg::FOUND_W-1:0];
                        break;
                    end
                end
            end
            isws_pkg::OP_CLEAR: begin
                shadow_count = 0;
            end
            default: begin
            end
        endcase
        r.count = shadow_count[isws_pkg::COUNT_W-1:0];
        return r;
    endfunction

    // Drive one request, hold it until accepted, then log what it owes.
    // Returns on the accepting edge, so a following request keeps valid high.
    task automatic send_request(input logic [isws_pkg::OP_W-1:0]  op,
                                input logic [isws_pkg::POS_W-1:0] pos,
                                input logic [isws_pkg::VAL_W-1:0] val,
                                input logic                       typed,
                                input t_stack_rsp                 typed_rsp);
        t_stack_rsp predicted;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.operation <= op;
        req_bus.position  <= pos;
        req_bus.value     <= val;
        @(posedge i_clk);
        while (req_bus.ready !== 1'b1) @(posedge i_clk);
        predicted = apply_stack_op(op, pos, val);
        pending_rsp_q.push_back(typed ? typed_rsp : predicted);
    endtask

    // Stop sending and wait until every owed response has been claimed.
    task automatic drain_responses();
        req_bus.valid <= 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
    endtask

    // Sink side: throttle ready at random, except during the calm stretch.
    initial begin
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Check each claimed response against the oldest owed one, field by field.
    always @(posedge i_clk) begin
        t_stack_rsp got;
        t_stack_rsp want;
        if (i_rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.read_value     = rsp_bus.read_value;
            got.found_position = rsp_bus.found_position;
            got.count          = rsp_bus.count;
            got.status         = isws_pkg::t_status'(rsp_bus.status);
            if (pending_rsp_q.size() == 0) begin
                flag_error($sformatf("response %0d with no request outstanding", rsp_seen));
            end else begin
                want = pending_rsp_q.pop_front();
                if (got.read_value !== want.read_value)
                    flag_error($sformatf("response %0d read_value got %h want %h",
                                         rsp_seen, got.read_value, want.read_value));
                if (got.found_position !== want.found_position)
                    flag_error($sformatf("response %0d found_position got %h want %h",
                                         rsp_seen, got.found_position, want.found_position));
                if (got.count !== want.count)
                    flag_error($sformatf("response %0d count got %0d want %0d",
                                         rsp_seen, got.count, want.count));
                if (got.status !== want.status)
                    flag_error($sformatf("response %0d status got %0d want %0d",
                                         rsp_seen, got.status, want.status));
            end
            rsp_seen++;
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
            (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [isws_pkg::OP_W-1:0]  op;
        logic [isws_pkg::POS_W-1:0] pos;
        logic [isws_pkg::VAL_W-1:0] val;
        int unsigned                pick;
        int unsigned                top;

        err_count    = 0;
        rsp_seen     = 0;
        quiet_cycles = 0;
        calm         = 1'b0;
        shadow_count = 0;
        for (int k = 0; k < STACK_DEPTH; k++) shadow_mem[SHADOW_AW'(k)] = '0;

        // Hold every input at a known value, then reset once.
        i_rst_n           <= 1'b0;
        req_bus.valid     <= 1'b0;
        req_bus.operation <= isws_pkg::OP_PUSH;
        req_bus.position  <= '0;
        req_bus.value     <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table.
        for (int r = 0; r < N_DIRECTED; r++) begin
            send_request(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].pos, DIRECTED_ROWS[r].val,
                         DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].rsp);
        end
        drain_responses();

        // Random traffic, shaped by what the shadow stack currently holds.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 250 && n < 380);
            if (n == 400) drain_responses();

            pick = $urandom_range(0, 99);
            pos  = isws_pkg::POS_W'($urandom_range(0, 255));
            val  = $urandom();
            if (pick < 31) begin
                op = isws_pkg::OP_PUSH;
                // mix in extremes and duplicates so find sees repeated keys
                case ($urandom_range(0, 7))
                    0: val = 32'h7FFF_FFFF;
                    1: val = 32'h8000_0000;
                    2: val = '0;
                    3: if (shadow_count > 0)
                           val = shadow_mem[SHADOW_AW'($urandom_range(0, shadow_count - 1))];
                    default: ;
                endcase
            end else if (pick < 45) begin
                op = isws_pkg::OP_POP;
            end else if (pick < 60) begin
                op  = isws_pkg::OP_SET;
                top = shadow_count + $urandom_range(0, 8);
                case ($urandom_range(0, 9))
                    0: ;    // anywhere, sometimes a long zero fill
                    1, 2, 3: pos = isws_pkg::POS_W'((top > 255) ? 255 : top);
                    default: if (shadow_count > 0)
                                 pos = isws_pkg::POS_W'($urandom_range(0, shadow_count - 1));
                endcase
            end else if (pick < 75) begin
                op = isws_pkg::OP_GET;
                if (shadow_count > 0 && $urandom_range(0, 9) < 8)
                    pos = isws_pkg::POS_W'($urandom_range(0, shadow_count - 1));
            end else if (pick < 92) begin
                op = isws_pkg::OP_FIND;
                case ($urandom_range(0, 5))
                    0: val = '0;
                    1, 2, 3: if (shadow_count > 0)
                                 val = shadow_mem[SHADOW_AW'($urandom_range(0,
                                                                            shadow_count - 1))];
                    default: ;
                endcase
            end else if (pick < 96) begin
                op = isws_pkg::OP_CLEAR;
            end else begin
                op = ($urandom_range(0, 1) == 0) ? OP_UNUSED_6 : OP_UNUSED_7;
            end
            send_request(op, pos, val, 1'b0, NO_RSP);
        end

        // Let the tail drain, then allow for a late stray response.
        calm = 1'b0;
        drain_responses();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
